### rtl/core/ledmode_pkg.sv
// ----------------------------------------------------------------------------
// ledmode_pkg
// Shared widths, reset values, mode codes and register indexes for the
// two-LED blink / breathing driver.
// ----------------------------------------------------------------------------
package ledmode_pkg;

   localparam int MODE_W   = 3;
   localparam int RELOAD_W = 24;
   localparam int STEPS_W  = 16;
   localparam int COUNT_W  = RELOAD_W + 1;
   localparam int CSR_W    = RELOAD_W;
   localparam int CSR_IDX_W = 1;
   localparam int BIT_IDX_W = $clog2(STEPS_W);

   localparam int MODE_COUNT_DEFAULT = 5;

   localparam logic [RELOAD_W-1:0] BLINK_RELOAD_RST = RELOAD_W'(20000);
   localparam logic [STEPS_W-1:0]  BREATH_STEPS_RST = STEPS_W'(404);
   localparam logic [COUNT_W-1:0]  BLINK_COUNT_RST  = COUNT_W'(20000);

   // display modes
   localparam logic [MODE_W-1:0] MODE_OFF    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_BREATH = 3'd1;
   localparam logic [MODE_W-1:0] MODE_BLINK  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_BOTH   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_ON     = 3'd4;

   // item kinds
   localparam logic KIND_TICK   = 1'b0;
   localparam logic KIND_BUTTON = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_RELOAD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BREATH_STEPS = 1'd1;

endpackage

### rtl/core/led_mode_blink_breathing_driver.sv
// ----------------------------------------------------------------------------
// led_mode_blink_breathing_driver
// Five-mode driver for two active-low LEDs: off, breathing, blink, both
// effects, and on. Button transactions advance the mode, tick transactions
// step the effects.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  req     | in        | req_valid/req_stall| req_kind, req_pin_low
//  rsp     | out       | rsp_valid/rsp_stall| rsp_led_fire, rsp_led_thrust,
//          |           |                    | rsp_mode_now
//  csr     | in        | csr_write_enable   | csr_index, csr_data
//
// Cycles: one transaction per clock while req is not stalled. Each response
//   is registered in the output register, or in the skid while that holds
//   an untaken one; state update and response share one compare/increment stage.
// Stalls: a two-entry output (response register plus skid) means req_stall
//   never follows rsp_stall in the same cycle; req stalls while the skid
//   holds a response or a remainder pass runs.
// Writing breath_steps starts a remainder pass (one dividend bit a cycle)
//   that rebases the duty counter on the new period; req stalls until the
//   pass ends.
// Reset: synchronous, active high; clears mode, counters and both handshakes.
// ----------------------------------------------------------------------------
module led_mode_blink_breathing_driver
   import ledmode_pkg::*;
#(
   parameter int MODE_COUNT = MODE_COUNT_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_kind,
   input  logic                 req_pin_low,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_led_fire,
   output logic                 rsp_led_thrust,
   output logic [MODE_W-1:0]    rsp_mode_now,
   // configuration
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data
);

   localparam logic [MODE_W-1:0] MODE_LAST = MODE_W'(MODE_COUNT - 1);

   // configuration registers
   logic [RELOAD_W-1:0] blink_reload_ff;
   logic [STEPS_W-1:0]  breath_steps_ff;

   // effect state
   logic [MODE_W-1:0]   display_mode_ff, display_mode_in;
   logic [COUNT_W-1:0]  blink_count_ff,  blink_count_in;
   logic                blink_level_ff,  blink_level_in;
   logic [STEPS_W-1:0]  duty_step_ff,    duty_step_in;
   logic [STEPS_W-1:0]  duty_red_ff,     duty_red_in;   // duty_step mod breath_steps
   logic [STEPS_W-1:0]  phase_index_ff,  phase_index_in;
   logic                rising_ff,       rising_in;
   logic                pin_one_ff,      pin_one_in;
   logic                pin_two_ff,      pin_two_in;

   // remainder pass
   logic                 busy_ff;
   logic [BIT_IDX_W-1:0] bit_ff;
   logic [STEPS_W-1:0]   rem_ff;
   logic [STEPS_W:0]     rem_shift;
   logic [STEPS_W:0]     rem_sub;

   // output register and skid
   logic                 rsp_valid_ff;
   logic                 fire_ff, thrust_ff;
   logic [MODE_W-1:0]    mode_out_ff;
   logic                 skid_valid_ff;
   logic                 skid_fire_ff, skid_thrust_ff;
   logic [MODE_W-1:0]    skid_mode_ff;

   logic accept, take;

   // breathing step intermediates
   logic                wrap;
   logic [STEPS_W:0]    red_inc;
   logic [STEPS_W-1:0]  duty_wrap;
   logic [STEPS_W-1:0]  duty_cur;
   logic [STEPS_W-1:0]  phase_cur;
   logic                rising_cur;
   logic                below;
   // blink step intermediates
   logic                blink_neg;
   logic [COUNT_W-1:0]  blink_base;

   assign req_stall = busy_ff | skid_valid_ff;
   assign accept    = req_valid & ~req_stall;
   assign take      = rsp_valid_ff & ~rsp_stall;

   // ---- effect steps -------------------------------------------------------
   assign blink_neg  = blink_count_ff[COUNT_W-1];
   assign blink_base = blink_neg ? {1'b0, blink_reload_ff} : blink_count_ff;

   assign wrap      = (phase_index_ff == breath_steps_ff);
   assign red_inc   = {1'b0, duty_red_ff} + (STEPS_W+1)'(1);
   // zero period or increment reaching the period both land on zero
   assign duty_wrap = ((breath_steps_ff == '0) || (red_inc == {1'b0, breath_steps_ff}))
                      ? '0 : red_inc[STEPS_W-1:0];
   assign duty_cur   = wrap ? duty_wrap : duty_step_ff;
   assign phase_cur  = wrap ? '0 : phase_index_ff;
   assign rising_cur = (wrap && (duty_wrap == '0)) ? ~rising_ff : rising_ff;
   assign below      = phase_cur < duty_cur;

   always_comb begin
      display_mode_in = display_mode_ff;
      blink_count_in  = blink_count_ff;
      blink_level_in  = blink_level_ff;
      duty_step_in    = duty_step_ff;
      duty_red_in     = duty_red_ff;
      phase_index_in  = phase_index_ff;
      rising_in       = rising_ff;
      pin_one_in      = pin_one_ff;
      pin_two_in      = pin_two_ff;

      if (req_kind == KIND_BUTTON) begin
         if (req_pin_low) begin
            display_mode_in = (display_mode_ff == MODE_LAST) ? MODE_OFF
                              : display_mode_ff + MODE_W'(1);
         end
      end else begin
         case (display_mode_ff)
            MODE_OFF: begin
               pin_one_in = 1'b1;
               pin_two_in = 1'b1;
            end
            MODE_BREATH, MODE_BLINK, MODE_BOTH: begin
               if (display_mode_ff == MODE_BREATH) begin
                  pin_one_in = 1'b1;
               end else begin
                  blink_count_in = blink_base - COUNT_W'(1);
                  if (blink_neg) begin
                     blink_level_in = ~blink_level_ff;
                     pin_one_in     = ~blink_level_ff;
                  end
               end
               if (display_mode_ff == MODE_BLINK) begin
                  pin_two_in = 1'b1;
               end else begin
                  duty_step_in   = duty_cur;
                  duty_red_in    = wrap ? duty_wrap : duty_red_ff;
                  rising_in      = rising_cur;
                  phase_index_in = phase_cur + STEPS_W'(1);
                  pin_two_in     = rising_cur ? ~below : below;
               end
            end
            MODE_ON: begin
               pin_one_in = 1'b0;
               pin_two_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // ---- remainder pass: duty_step mod breath_steps, MSB first -------------
   assign rem_shift = {rem_ff, duty_step_ff[bit_ff]};
   assign rem_sub   = rem_shift - {1'b0, breath_steps_ff};

   // ---- control and state --------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         blink_reload_ff <= BLINK_RELOAD_RST;
         breath_steps_ff <= BREATH_STEPS_RST;
         display_mode_ff <= MODE_OFF;
         blink_count_ff  <= BLINK_COUNT_RST;
         blink_level_ff  <= 1'b0;
         duty_step_ff    <= '0;
         duty_red_ff     <= '0;
         phase_index_ff  <= '0;
         rising_ff       <= 1'b1;
         pin_one_ff      <= 1'b1;
         pin_two_ff      <= 1'b1;
         busy_ff         <= 1'b0;
         bit_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_BLINK_RELOAD: blink_reload_ff <= csr_data[RELOAD_W-1:0];
               CSR_BREATH_STEPS: breath_steps_ff <= csr_data[STEPS_W-1:0];
               default: begin
               end
            endcase
         end

         // a blink_reload write leaves a running pass alone
         if (csr_write_enable && (csr_index == CSR_BREATH_STEPS)) begin
            busy_ff <= 1'b1;
            bit_ff  <= BIT_IDX_W'(STEPS_W - 1);
         end else if (busy_ff) begin
            bit_ff <= bit_ff - BIT_IDX_W'(1);
            if (bit_ff == '0) begin
               busy_ff     <= 1'b0;
               duty_red_ff <= rem_sub[STEPS_W] ? rem_shift[STEPS_W-1:0]
                                                : rem_sub[STEPS_W-1:0];
            end
         end

         if (accept) begin
            display_mode_ff <= display_mode_in;
            blink_count_ff  <= blink_count_in;
            blink_level_ff  <= blink_level_in;
            duty_step_ff    <= duty_step_in;
            duty_red_ff     <= duty_red_in;
            phase_index_ff  <= phase_index_in;
            rising_ff       <= rising_in;
            pin_one_ff      <= pin_one_in;
            pin_two_ff      <= pin_two_in;
         end

         if (skid_valid_ff) begin
            if (take) begin
               skid_valid_ff <= 1'b0;
            end
         end else if (accept) begin
            if (rsp_valid_ff && !take) begin
               skid_valid_ff <= 1'b1;
            end else begin
               rsp_valid_ff <= 1'b1;
            end
         end else if (take) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // remainder accumulator and response payload: no reset needed
   always_ff @(posedge clock) begin
      if (csr_write_enable && (csr_index == CSR_BREATH_STEPS)) begin
         rem_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_sub[STEPS_W] ? rem_shift[STEPS_W-1:0] : rem_sub[STEPS_W-1:0];
      end

      if (skid_valid_ff) begin
         if (take) begin
            fire_ff     <= skid_fire_ff;
            thrust_ff   <= skid_thrust_ff;
            mode_out_ff <= skid_mode_ff;
         end
      end else if (accept) begin
         if (rsp_valid_ff && !take) begin
            skid_fire_ff   <= pin_one_in;
            skid_thrust_ff <= pin_two_in;
            skid_mode_ff   <= display_mode_in;
         end else begin
            fire_ff     <= pin_one_in;
            thrust_ff   <= pin_two_in;
            mode_out_ff <= display_mode_in;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_led_fire   = fire_ff;
   assign rsp_led_thrust = thrust_ff;
   assign rsp_mode_now   = mode_out_ff;

   // ---- assertions ---------------------------------------------------------
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a response while the output register is empty");

   a_mode_range: assert property (@(posedge clock) disable iff (reset)
      display_mode_ff <= MODE_LAST)
      else $error("display mode beyond last mode");

   a_blink_floor: assert property (@(posedge clock) disable iff (reset)
      blink_count_ff[COUNT_W-1] |-> (blink_count_ff == '1))
      else $error("blink countdown went below -1");

   a_duty_reduced: assert property (@(posedge clock) disable iff (reset)
      (!busy_ff && (breath_steps_ff != '0)) |-> (duty_red_ff < breath_steps_ff))
      else $error("reduced duty not below period");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> $stable(duty_step_ff))
      else $error("duty step moved during remainder pass");

endmodule
